@@ rtl/dfme_pkg.sv @@
// Shared constants, types and grid helpers for the depth-first maze explorer.
`timescale 1ns / 1ps

package dfme_pkg;

  localparam int unsigned HALF_SPAN = 32;
  localparam int unsigned SIDE      = 2 * HALF_SPAN + 1;
  localparam int unsigned CELLS     = SIDE * SIDE;
  localparam int unsigned CW        = $clog2(SIDE);
  localparam int unsigned AW        = $clog2(CELLS);
  localparam int unsigned PW        = 7;
  localparam int unsigned UPC_W     = 5;

  typedef logic [CW-1:0] coord_t;
  typedef logic [AW-1:0] addr_t;

  typedef struct packed {
    coord_t x;
    coord_t y;
  } pos_t;

  localparam pos_t CENTRE = '{x: coord_t'(HALF_SPAN), y: coord_t'(HALF_SPAN)};

  typedef enum logic [1:0] {
    DIR_UP    = 2'd0,
    DIR_RIGHT = 2'd1,
    DIR_DOWN  = 2'd2,
    DIR_LEFT  = 2'd3
  } dir_e;

  typedef enum logic [1:0] {
    CMD_BEGIN   = 2'd0,
    CMD_SENSE   = 2'd1,
    CMD_OUTCOME = 2'd2
  } cmd_e;

  typedef enum logic [2:0] {
    ST_STARTED      = 3'd0,
    ST_CHOSEN       = 3'd1,
    ST_MOVED        = 3'd2,
    ST_EXPLORED     = 3'd3,
    ST_MET          = 3'd4,
    ST_OFF_GRID     = 3'd5,
    ST_OUT_OF_ORDER = 3'd6
  } status_e;

  typedef enum logic [3:0] {
    OP_NOP,
    OP_ACK,
    OP_MEET_REC,
    OP_MOVE,
    OP_END,
    OP_INIT,
    OP_CLR,
    OP_MARK,
    OP_SCAN_INIT,
    OP_BACKDIR,
    OP_COMMIT
  } op_e;

  typedef enum logic [3:0] {
    RES_NONE,
    RES_STARTED,
    RES_CHOSEN,
    RES_MOVED,
    RES_EXPLORED,
    RES_MEET,
    RES_OFF_D,
    RES_OFF_P,
    RES_BAD
  } res_e;

  typedef enum logic [3:0] {
    C_NEVER,
    C_ALWAYS,
    C_NOSTART,
    C_INVALID,
    C_BEGIN,
    C_SENSE,
    C_OFF_P,
    C_MET_STOP,
    C_CLR_MORE,
    C_EXHAUSTED,
    C_OFF_D
  } cond_e;

  typedef struct packed {
    logic       latch;
    op_e        op;
    logic       rd_cur;
    logic [1:0] rd_dir;
    logic       ev;
    logic [1:0] ev_dir;
    res_e       res;
  } ctrl_t;

  typedef struct packed {
    logic invalid;
    logic is_begin;
    logic is_sense;
    logic off_p;
    logic met_stop;
    logic clr_more;
    logic exhausted;
    logic off_d;
  } flags_t;

  function automatic pos_t step_pos(pos_t p, logic [1:0] d);
    pos_t r;
    r = p;
    case (dir_e'(d))
      DIR_UP:    r.y = p.y - coord_t'(1);
      DIR_RIGHT: r.x = p.x + coord_t'(1);
      DIR_DOWN:  r.y = p.y + coord_t'(1);
      DIR_LEFT:  r.x = p.x - coord_t'(1);
      default:   r = p;
    endcase
    return r;
  endfunction

  function automatic logic off_grid(pos_t p, logic [1:0] d);
    logic o;
    case (dir_e'(d))
      DIR_UP:    o = (p.y == coord_t'(0));
      DIR_RIGHT: o = (p.x == coord_t'(SIDE - 1));
      DIR_DOWN:  o = (p.y == coord_t'(SIDE - 1));
      DIR_LEFT:  o = (p.x == coord_t'(0));
      default:   o = 1'b0;
    endcase
    return o;
  endfunction

  function automatic addr_t cell_addr(pos_t p);
    return addr_t'(addr_t'(p.y) * addr_t'(SIDE) + addr_t'(p.x));
  endfunction

endpackage

@@ rtl/depth_first_maze_explorer_unit.sv @@
// Depth-first maze explorer top level: microcode sequencer plus datapath.
// Begin clears the 4225-cell map memory one entry per cycle.
// One item at a time; busy stays high until the result strobe, which lasts one cycle.
// Results cannot be stalled. Reset is asynchronous, active low; no clear pass after reset.
`timescale 1ns / 1ps

module depth_first_maze_explorer_unit (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    start,
  output logic                    busy,
  input  logic [1:0]              cmd_i,
  input  logic [3:0]              open_mask_i,
  input  logic                    met_i,
  input  logic                    cfg_we_i,
  input  logic                    keep_exploring_i,
  output logic                    done_o,
  output logic [2:0]              status_o,
  output logic [1:0]              direction_o,
  output logic                    forward_o,
  output logic [dfme_pkg::PW-1:0] pos_x_o,
  output logic [dfme_pkg::PW-1:0] pos_y_o,
  output logic                    met_seen_o,
  output logic [dfme_pkg::PW-1:0] meet_x_o,
  output logic [dfme_pkg::PW-1:0] meet_y_o
);
  import dfme_pkg::*;

  ctrl_t  ctrl;
  flags_t flags;

  dfme_useq u_useq (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start   (start),
    .flags_i (flags),
    .ctrl_o  (ctrl),
    .busy    (busy)
  );

  dfme_dpath u_dpath (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .ctrl_i           (ctrl),
    .flags_o          (flags),
    .cmd_i            (cmd_i),
    .open_mask_i      (open_mask_i),
    .met_i            (met_i),
    .cfg_we_i         (cfg_we_i),
    .keep_exploring_i (keep_exploring_i),
    .done_o           (done_o),
    .status_o         (status_o),
    .direction_o      (direction_o),
    .forward_o        (forward_o),
    .pos_x_o          (pos_x_o),
    .pos_y_o          (pos_y_o),
    .met_seen_o       (met_seen_o),
    .meet_x_o         (meet_x_o),
    .meet_y_o         (meet_y_o)
  );

  a_done_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> !busy)
    else $error("result strobe while sequencer busy");

  a_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy) |=> busy)
    else $error("accepted transfer did not start the sequencer");

  a_single_strobe: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |=> !done_o)
    else $error("back-to-back result strobes");

  a_begin_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && (status_o == ST_STARTED)) |->
      ((pos_x_o == PW'(HALF_SPAN)) && (pos_y_o == PW'(HALF_SPAN)) && !met_seen_o))
    else $error("begin result not at centre with cleared meet record");

endmodule

@@ rtl/dfme_useq.sv @@
// Microcode sequencer: step counter, control store and conditional jumps.
`timescale 1ns / 1ps

module dfme_useq (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start,
  input  dfme_pkg::flags_t flags_i,
  output dfme_pkg::ctrl_t  ctrl_o,
  output logic             busy
);
  import dfme_pkg::*;

  localparam logic [UPC_W-1:0] A_IDLE = UPC_W'(0);
  localparam logic [UPC_W-1:0] A_CHK  = UPC_W'(1);
  localparam logic [UPC_W-1:0] A_ISB  = UPC_W'(2);
  localparam logic [UPC_W-1:0] A_ISS  = UPC_W'(3);
  localparam logic [UPC_W-1:0] A_OUT0 = UPC_W'(4);
  localparam logic [UPC_W-1:0] A_OUT1 = UPC_W'(5);
  localparam logic [UPC_W-1:0] A_OUT2 = UPC_W'(6);
  localparam logic [UPC_W-1:0] A_OUT3 = UPC_W'(7);
  localparam logic [UPC_W-1:0] A_MEET = UPC_W'(8);
  localparam logic [UPC_W-1:0] A_OFFP = UPC_W'(9);
  localparam logic [UPC_W-1:0] A_BAD  = UPC_W'(10);
  localparam logic [UPC_W-1:0] A_BEG  = UPC_W'(11);
  localparam logic [UPC_W-1:0] A_CLR  = UPC_W'(12);
  localparam logic [UPC_W-1:0] A_MARK = UPC_W'(13);
  localparam logic [UPC_W-1:0] A_BRES = UPC_W'(14);
  localparam logic [UPC_W-1:0] A_SEN0 = UPC_W'(15);
  localparam logic [UPC_W-1:0] A_SEN1 = UPC_W'(16);
  localparam logic [UPC_W-1:0] A_SEN2 = UPC_W'(17);
  localparam logic [UPC_W-1:0] A_SEN3 = UPC_W'(18);
  localparam logic [UPC_W-1:0] A_SEN4 = UPC_W'(19);
  localparam logic [UPC_W-1:0] A_BACK = UPC_W'(20);
  localparam logic [UPC_W-1:0] A_CHKD = UPC_W'(21);
  localparam logic [UPC_W-1:0] A_CHOS = UPC_W'(22);
  localparam logic [UPC_W-1:0] A_EXPL = UPC_W'(23);
  localparam logic [UPC_W-1:0] A_OFFD = UPC_W'(24);

  logic [UPC_W-1:0] upc_q, upc_d;
  ctrl_t            cw;
  cond_e            cond;
  logic [UPC_W-1:0] target;
  logic             take;

  // control store
  always_comb begin
    cw     = '0;
    cond   = C_NEVER;
    target = A_IDLE;
    case (upc_q)
      A_IDLE: begin cond = C_NOSTART; target = A_IDLE; end
      A_CHK:  begin cond = C_INVALID; target = A_BAD; end
      A_ISB:  begin cond = C_BEGIN; target = A_BEG; end
      A_ISS:  begin cond = C_SENSE; target = A_SEN0; end
      A_OUT0: begin cw.op = OP_ACK; cond = C_OFF_P; target = A_OFFP; end
      A_OUT1: begin cw.op = OP_MEET_REC; cond = C_MET_STOP; target = A_MEET; end
      A_OUT2: begin cw.op = OP_MOVE; end
      A_OUT3: begin cw.res = RES_MOVED; cond = C_ALWAYS; end
      A_MEET: begin cw.op = OP_END; cw.res = RES_MEET; cond = C_ALWAYS; end
      A_OFFP: begin cw.op = OP_END; cw.res = RES_OFF_P; cond = C_ALWAYS; end
      A_BAD:  begin cw.res = RES_BAD; cond = C_ALWAYS; end
      A_BEG:  begin cw.op = OP_INIT; end
      A_CLR:  begin cw.op = OP_CLR; cond = C_CLR_MORE; target = A_CLR; end
      A_MARK: begin cw.op = OP_MARK; end
      A_BRES: begin cw.res = RES_STARTED; cond = C_ALWAYS; end
      A_SEN0: begin cw.op = OP_SCAN_INIT; cw.rd_dir = DIR_UP; end
      A_SEN1: begin
        cw.rd_dir = DIR_RIGHT; cw.ev = 1'b1; cw.ev_dir = DIR_UP;
      end
      A_SEN2: begin
        cw.rd_dir = DIR_DOWN; cw.ev = 1'b1; cw.ev_dir = DIR_RIGHT;
      end
      A_SEN3: begin
        cw.rd_dir = DIR_LEFT; cw.ev = 1'b1; cw.ev_dir = DIR_DOWN;
      end
      A_SEN4: begin
        cw.rd_cur = 1'b1; cw.ev = 1'b1; cw.ev_dir = DIR_LEFT;
      end
      A_BACK: begin cw.op = OP_BACKDIR; cond = C_EXHAUSTED; target = A_EXPL; end
      A_CHKD: begin cond = C_OFF_D; target = A_OFFD; end
      A_CHOS: begin cw.op = OP_COMMIT; cw.res = RES_CHOSEN; cond = C_ALWAYS; end
      A_EXPL: begin cw.op = OP_END; cw.res = RES_EXPLORED; cond = C_ALWAYS; end
      A_OFFD: begin cw.op = OP_END; cw.res = RES_OFF_D; cond = C_ALWAYS; end
      default: begin cond = C_ALWAYS; end
    endcase
  end

  always_comb begin
    case (cond)
      C_NEVER:     take = 1'b0;
      C_ALWAYS:    take = 1'b1;
      C_NOSTART:   take = !start;
      C_INVALID:   take = flags_i.invalid;
      C_BEGIN:     take = flags_i.is_begin;
      C_SENSE:     take = flags_i.is_sense;
      C_OFF_P:     take = flags_i.off_p;
      C_MET_STOP:  take = flags_i.met_stop;
      C_CLR_MORE:  take = flags_i.clr_more;
      C_EXHAUSTED: take = flags_i.exhausted;
      C_OFF_D:     take = flags_i.off_d;
      default:     take = 1'b0;
    endcase
    upc_d = take ? target : upc_q + UPC_W'(1);
  end

  always_comb begin
    ctrl_o       = cw;
    ctrl_o.latch = (upc_q == A_IDLE) && start;
  end

  assign busy = (upc_q != A_IDLE);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      upc_q <= A_IDLE;
    end else begin
      upc_q <= upc_d;
    end
  end

endmodule

@@ rtl/dfme_dpath.sv @@
// Explorer datapath: walk state, visited/arrival map memory and result registers.
`timescale 1ns / 1ps

module dfme_dpath (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  dfme_pkg::ctrl_t         ctrl_i,
  output dfme_pkg::flags_t        flags_o,
  input  logic [1:0]              cmd_i,
  input  logic [3:0]              open_mask_i,
  input  logic                    met_i,
  input  logic                    cfg_we_i,
  input  logic                    keep_exploring_i,
  output logic                    done_o,
  output logic [2:0]              status_o,
  output logic [1:0]              direction_o,
  output logic                    forward_o,
  output logic [dfme_pkg::PW-1:0] pos_x_o,
  output logic [dfme_pkg::PW-1:0] pos_y_o,
  output logic                    met_seen_o,
  output logic [dfme_pkg::PW-1:0] meet_x_o,
  output logic [dfme_pkg::PW-1:0] meet_y_o
);
  import dfme_pkg::*;

  // map entry: [2] visited, [1:0] arrival direction
  logic [2:0] map_mem [CELLS];
  logic [2:0] rdata_q;

  logic       keep_q;
  logic [1:0] cmd_q;
  logic [3:0] mask_q;
  logic       met_q;

  pos_t       agent_q, agent_d;
  logic [1:0] pdir_q, pdir_d;
  logic       pfwd_q, pfwd_d;
  logic       await_q, await_d;
  logic       wdone_q, wdone_d;
  logic       mflag_q, mflag_d;
  pos_t       meet_q, meet_d;
  logic       found_q, found_d;
  logic [1:0] dir_q, dir_d;
  addr_t      clr_q, clr_d;

  logic       mem_we;
  addr_t      mem_waddr;
  logic [2:0] mem_wdata;
  addr_t      mem_raddr;
  pos_t       tgt_p;
  pos_t       nb_pos;

  logic       done_q;
  logic [2:0] status_q;
  logic [1:0] odir_q;
  logic       ofwd_q;
  pos_t       opos_q;
  logic       omet_q;
  pos_t       omeet_q;

  assign tgt_p  = step_pos(agent_q, pdir_q);
  assign nb_pos = step_pos(agent_q, ctrl_i.rd_dir);

  always_comb begin
    flags_o.invalid   = ((cmd_q == CMD_SENSE) && (wdone_q || await_q)) ||
                        ((cmd_q == CMD_OUTCOME) && (wdone_q || !await_q)) ||
                        !((cmd_q == CMD_BEGIN) || (cmd_q == CMD_SENSE) ||
                          (cmd_q == CMD_OUTCOME));
    flags_o.is_begin  = (cmd_q == CMD_BEGIN);
    flags_o.is_sense  = (cmd_q == CMD_SENSE);
    flags_o.off_p     = off_grid(agent_q, pdir_q);
    flags_o.met_stop  = met_q && !keep_q;
    flags_o.clr_more  = (clr_q != addr_t'(CELLS - 1));
    flags_o.exhausted = !found_q && (agent_q == CENTRE);
    flags_o.off_d     = off_grid(agent_q, dir_q);
  end

  // off-grid neighbours read the current cell; the data is ignored then
  always_comb begin
    if (ctrl_i.rd_cur || off_grid(agent_q, ctrl_i.rd_dir)) begin
      mem_raddr = cell_addr(agent_q);
    end else begin
      mem_raddr = cell_addr(nb_pos);
    end
  end

  always_comb begin
    agent_d   = agent_q;
    pdir_d    = pdir_q;
    pfwd_d    = pfwd_q;
    await_d   = await_q;
    wdone_d   = wdone_q;
    mflag_d   = mflag_q;
    meet_d    = meet_q;
    found_d   = found_q;
    dir_d     = dir_q;
    clr_d     = clr_q;
    mem_we    = 1'b0;
    mem_waddr = clr_q;
    mem_wdata = 3'b000;
    case (ctrl_i.op)
      OP_NOP: ;
      OP_ACK: await_d = 1'b0;
      OP_MEET_REC: begin
        if (met_q) begin
          mflag_d = 1'b1;
          meet_d  = tgt_p;
        end
      end
      OP_MOVE: begin
        agent_d = tgt_p;
        if (pfwd_q) begin
          mem_we    = 1'b1;
          mem_waddr = cell_addr(tgt_p);
          mem_wdata = {1'b1, 2'(pdir_q + 2'd2)};
        end
      end
      OP_END: wdone_d = 1'b1;
      OP_INIT: begin
        agent_d = CENTRE;
        pdir_d  = 2'd0;
        pfwd_d  = 1'b0;
        await_d = 1'b0;
        wdone_d = 1'b0;
        mflag_d = 1'b0;
        meet_d  = '0;
        clr_d   = '0;
      end
      OP_CLR: begin
        mem_we    = 1'b1;
        mem_waddr = clr_q;
        mem_wdata = 3'b000;
        clr_d     = clr_q + addr_t'(1);
      end
      OP_MARK: begin
        mem_we    = 1'b1;
        mem_waddr = cell_addr(CENTRE);
        mem_wdata = 3'b100;
      end
      OP_SCAN_INIT: begin
        found_d = 1'b0;
        dir_d   = 2'd0;
      end
      OP_BACKDIR: begin
        if (!found_q) dir_d = rdata_q[1:0];
      end
      OP_COMMIT: begin
        pdir_d  = dir_q;
        pfwd_d  = found_q;
        await_d = 1'b1;
      end
      default: ;
    endcase
    // later open unvisited sides win
    if (ctrl_i.ev && mask_q[ctrl_i.ev_dir] &&
        (off_grid(agent_q, ctrl_i.ev_dir) || !rdata_q[2])) begin
      found_d = 1'b1;
      dir_d   = ctrl_i.ev_dir;
    end
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) map_mem[mem_waddr] <= mem_wdata;
    rdata_q <= map_mem[mem_raddr];
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.latch) begin
      cmd_q  <= cmd_i;
      mask_q <= open_mask_i;
      met_q  <= met_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      keep_q  <= 1'b0;
      agent_q <= CENTRE;
      pdir_q  <= 2'd0;
      pfwd_q  <= 1'b0;
      await_q <= 1'b0;
      wdone_q <= 1'b1;
      mflag_q <= 1'b0;
      meet_q  <= '0;
      found_q <= 1'b0;
      dir_q   <= 2'd0;
      clr_q   <= '0;
    end else begin
      if (cfg_we_i) keep_q <= keep_exploring_i;
      agent_q <= agent_d;
      pdir_q  <= pdir_d;
      pfwd_q  <= pfwd_d;
      await_q <= await_d;
      wdone_q <= wdone_d;
      mflag_q <= mflag_d;
      meet_q  <= meet_d;
      found_q <= found_d;
      dir_q   <= dir_d;
      clr_q   <= clr_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      done_q <= 1'b0;
    end else begin
      done_q <= (ctrl_i.res != RES_NONE);
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.res != RES_NONE) begin
      opos_q  <= agent_q;
      omet_q  <= mflag_q;
      omeet_q <= meet_q;
      odir_q  <= 2'd0;
      ofwd_q  <= 1'b0;
      case (ctrl_i.res)
        RES_STARTED:  status_q <= ST_STARTED;
        RES_CHOSEN: begin
          status_q <= ST_CHOSEN;
          odir_q   <= dir_q;
          ofwd_q   <= found_q;
        end
        RES_MOVED: begin
          status_q <= ST_MOVED;
          odir_q   <= pdir_q;
          ofwd_q   <= pfwd_q;
        end
        RES_EXPLORED: status_q <= ST_EXPLORED;
        RES_MEET: begin
          status_q <= ST_MET;
          odir_q   <= pdir_q;
          ofwd_q   <= pfwd_q;
        end
        RES_OFF_D: begin
          status_q <= ST_OFF_GRID;
          odir_q   <= dir_q;
          ofwd_q   <= found_q;
        end
        RES_OFF_P: begin
          status_q <= ST_OFF_GRID;
          odir_q   <= pdir_q;
          ofwd_q   <= pfwd_q;
        end
        default: status_q <= ST_OUT_OF_ORDER;
      endcase
    end
  end

  assign done_o      = done_q;
  assign status_o    = status_q;
  assign direction_o = odir_q;
  assign forward_o   = ofwd_q;
  assign pos_x_o     = PW'(opos_q.x);
  assign pos_y_o     = PW'(opos_q.y);
  assign met_seen_o  = omet_q;
  assign meet_x_o    = PW'(omeet_q.x);
  assign meet_y_o    = PW'(omeet_q.y);

endmodule

@@ test/testbench.sv @@
// Self-checking testbench for the depth-first maze explorer unit.
`timescale 1ns / 1ps

module testbench;
  import dfme_pkg::*;

  localparam logic [1:0]  CMD_UNUSED  = 2'd3;
  localparam logic [1:0]  NO_DIR      = DIR_UP;
  localparam int          GRID        = int'(SIDE);
  localparam int          HOME        = int'(HALF_SPAN);
  localparam int unsigned CYCLE_LIMIT = 25_000_000;
  localparam int unsigned MAX_REPORTS = 10;
  localparam int unsigned MET_PCT     = 3;
  localparam int unsigned NOISE_PCT   = 8;

  typedef struct packed {
    logic [2:0]    status;
    logic [1:0]    direction;
    logic          forward;
    logic [PW-1:0] pos_x;
    logic [PW-1:0] pos_y;
    logic          met_seen;
    logic [PW-1:0] meet_x;
    logic [PW-1:0] meet_y;
  } report_t;

  logic          clk_i            = 1'b0;
  logic          rst_ni           = 1'b0;
  logic          start            = 1'b0;
  logic [1:0]    cmd_i            = CMD_BEGIN;
  logic [3:0]    open_mask_i      = 4'b0000;
  logic          met_i            = 1'b0;
  logic          cfg_we_i         = 1'b0;
  logic          keep_exploring_i = 1'b0;
  logic          busy;
  logic          done_o;
  logic [2:0]    status_o;
  logic [1:0]    direction_o;
  logic          forward_o;
  logic [PW-1:0] pos_x_o;
  logic [PW-1:0] pos_y_o;
  logic          met_seen_o;
  logic [PW-1:0] meet_x_o;
  logic [PW-1:0] meet_y_o;

  depth_first_maze_explorer_unit dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .start           (start),
    .busy            (busy),
    .cmd_i           (cmd_i),
    .open_mask_i     (open_mask_i),
    .met_i           (met_i),
    .cfg_we_i        (cfg_we_i),
    .keep_exploring_i(keep_exploring_i),
    .done_o          (done_o),
    .status_o        (status_o),
    .direction_o     (direction_o),
    .forward_o       (forward_o),
    .pos_x_o         (pos_x_o),
    .pos_y_o         (pos_y_o),
    .met_seen_o      (met_seen_o),
    .meet_x_o        (meet_x_o),
    .meet_y_o        (meet_y_o)
  );

  always #6 clk_i = ~clk_i;

  // Explorer state as predicted
  logic             keep_going   = 1'b0;
  logic [CELLS-1:0] seen_cells   = '0;
  logic [1:0]       came_from [CELLS];
  int               agent_col    = HOME;
  int               agent_row    = HOME;
  logic [1:0]       move_dir     = NO_DIR;
  logic             move_fwd     = 1'b0;
  logic             move_pending = 1'b0;
  logic             walk_over    = 1'b1;
  logic             meet_found   = 1'b0;
  int               meet_col     = 0;
  int               meet_row     = 0;

  report_t     expected_reports[$];
  int unsigned idle_pct     = 0;
  int unsigned items_sent   = 0;
  int unsigned walks        = 0;
  int unsigned results_seen = 0;
  int unsigned mismatches   = 0;
  int unsigned cycles       = 0;
  int unsigned status_count [8];

  function automatic logic neighbour(input logic [1:0] d, output int tx, output int ty);
    tx = agent_col;
    ty = agent_row;
    case (dir_e'(d))
      DIR_UP:    ty = ty - 1;
      DIR_RIGHT: tx = tx + 1;
      DIR_DOWN:  ty = ty + 1;
      default:   tx = tx - 1;
    endcase
    return tx >= 0 && ty >= 0 && tx < GRID && ty < GRID;
  endfunction

  function automatic report_t report(input status_e s, input logic [1:0] d, input logic f);
    report_t r;
    r.status    = s;
    r.direction = d;
    r.forward   = f;
    r.pos_x     = agent_col[PW-1:0];
    r.pos_y     = agent_row[PW-1:0];
    r.met_seen  = meet_found;
    r.meet_x    = meet_col[PW-1:0];
    r.meet_y    = meet_row[PW-1:0];
    return r;
  endfunction

  function automatic report_t explore_step(input logic [1:0] cmd, input logic [3:0] mask,
                                           input logic met);
    int         tx;
    int         ty;
    logic       found;
    logic [1:0] pick;
    tx = 0;
    ty = 0;
    case (cmd)
      CMD_BEGIN: begin
        seen_cells = '0;
        agent_col = HOME;
        agent_row = HOME;
        seen_cells[HOME * GRID + HOME] = 1'b1;
        move_dir = NO_DIR;
        move_fwd = 1'b0;
        move_pending = 1'b0;
        walk_over = 1'b0;
        meet_found = 1'b0;
        meet_col = 0;
        meet_row = 0;
        return report(ST_STARTED, NO_DIR, 1'b0);
      end
      CMD_SENSE: begin
        if (walk_over || move_pending) return report(ST_OUT_OF_ORDER, NO_DIR, 1'b0);
        found = 1'b0;
        pick = NO_DIR;
        // off-grid neighbours count as unvisited; the last hit wins
        for (int d = 0; d < 4; d++) begin
          if (mask[d] && (!neighbour(d[1:0], tx, ty) || !seen_cells[ty * GRID + tx])) begin
            found = 1'b1;
            pick = d[1:0];
          end
        end
        if (!found) begin
          if (agent_col == HOME && agent_row == HOME) begin
            walk_over = 1'b1;
            return report(ST_EXPLORED, NO_DIR, 1'b0);
          end
          pick = came_from[agent_row * GRID + agent_col];
        end
        if (!neighbour(pick, tx, ty)) begin
          walk_over = 1'b1;
          return report(ST_OFF_GRID, pick, found);
        end
        move_dir = pick;
        move_fwd = found;
        move_pending = 1'b1;
        return report(ST_CHOSEN, pick, found);
      end
      CMD_OUTCOME: begin
        if (walk_over || !move_pending) return report(ST_OUT_OF_ORDER, NO_DIR, 1'b0);
        move_pending = 1'b0;
        if (!neighbour(move_dir, tx, ty)) begin
          walk_over = 1'b1;
          return report(ST_OFF_GRID, move_dir, move_fwd);
        end
        if (met) begin
          meet_found = 1'b1;
          meet_col = tx;
          meet_row = ty;
          if (!keep_going) begin
            walk_over = 1'b1;
            return report(ST_MET, move_dir, move_fwd);
          end
        end
        agent_col = tx;
        agent_row = ty;
        if (move_fwd) begin
          seen_cells[ty * GRID + tx] = 1'b1;
          came_from[ty * GRID + tx] = move_dir + 2'd2;
        end
        return report(ST_MOVED, move_dir, move_fwd);
      end
      default: return report(ST_OUT_OF_ORDER, NO_DIR, 1'b0);
    endcase
  endfunction

  task automatic send_item(input logic [1:0] cmd, input logic [3:0] mask, input logic met);
    while ($urandom_range(99) < idle_pct) begin
      start <= 1'b0;
      @(posedge clk_i);
    end
    start <= 1'b1;
    cmd_i <= cmd;
    open_mask_i <= mask;
    met_i <= met;
    do @(posedge clk_i); while (busy !== 1'b0);
    expected_reports.push_back(explore_step(cmd, mask, met));
    items_sent++;
  endtask

  task automatic wait_idle();
    start <= 1'b0;
    do @(posedge clk_i); while (expected_reports.size() != 0 || busy !== 1'b0);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic set_keep(input logic value);
    wait_idle();
    cfg_we_i <= 1'b1;
    keep_exploring_i <= value;
    @(posedge clk_i);
    keep_going = value;
    cfg_we_i <= 1'b0;
    @(posedge clk_i);
  endtask

  // One walk from a begin; straight walks head for the grid border.
  task automatic run_walk(input logic straight, input logic [1:0] heading, input int cap,
                          output int n);
    logic [3:0] mask;
    logic [3:0] lower;
    n = 0;
    walks++;
    send_item(CMD_BEGIN, 4'($urandom_range(15)), 1'($urandom_range(1)));
    n++;
    while (!walk_over && n < cap) begin
      if (!straight && $urandom_range(99) < NOISE_PCT) begin
        send_item(2'($urandom_range(1, 3)), 4'($urandom_range(15)), 1'($urandom_range(1)));
      end else if (move_pending) begin
        send_item(CMD_OUTCOME, 4'($urandom_range(15)),
                  !straight && $urandom_range(99) < MET_PCT);
      end else begin
        lower = (4'b0001 << heading) - 4'd1;
        mask = straight ? ((4'b0001 << heading) | (4'($urandom) & lower)) : 4'($urandom);
        send_item(CMD_SENSE, mask, 1'($urandom_range(1)));
      end
      n++;
    end
    if (walk_over && $urandom_range(2) == 0) begin
      send_item(2'($urandom_range(1, 3)), 4'($urandom_range(15)), 1'($urandom_range(1)));
      n++;
    end
  endtask

  task automatic test_reset_state();
    send_item(CMD_SENSE, 4'b1111, 1'b1);
    send_item(CMD_OUTCOME, 4'b0000, 1'b1);
    send_item(CMD_UNUSED, 4'b1111, 1'b1);
  endtask

  task automatic test_start_cell();
    send_item(CMD_BEGIN, 4'b0000, 1'b0);
    send_item(CMD_OUTCOME, 4'b1111, 1'b0);
    send_item(CMD_SENSE, 4'b0000, 1'b0);
    send_item(CMD_SENSE, 4'b1111, 1'b0);
  endtask

  task automatic test_move_and_backtrack();
    send_item(CMD_BEGIN, 4'b1111, 1'b1);
    send_item(CMD_SENSE, 4'b1111, 1'b0);
    send_item(CMD_SENSE, 4'b1111, 1'b0);
    send_item(CMD_UNUSED, 4'b0000, 1'b0);
    send_item(CMD_OUTCOME, 4'b0000, 1'b0);
    send_item(CMD_SENSE, 4'b0010, 1'b0);
    send_item(CMD_OUTCOME, 4'b1111, 1'b0);
    send_item(CMD_SENSE, 4'b0000, 1'b1);
  endtask

  task automatic test_meeting();
    set_keep(1'b0);
    send_item(CMD_BEGIN, 4'b0000, 1'b0);
    send_item(CMD_SENSE, 4'b0001, 1'b0);
    send_item(CMD_OUTCOME, 4'b0000, 1'b1);
    send_item(CMD_SENSE, 4'b1111, 1'b0);
    set_keep(1'b1);
    send_item(CMD_BEGIN, 4'b0000, 1'b0);
    send_item(CMD_SENSE, 4'b1000, 1'b0);
    send_item(CMD_OUTCOME, 4'b0000, 1'b1);
    send_item(CMD_SENSE, 4'b0100, 1'b0);
    send_item(CMD_OUTCOME, 4'b0000, 1'b0);
  endtask

  task automatic test_grid_edge();
    int n;
    run_walk(1'b1, DIR_DOWN, 90, n);
    run_walk(1'b1, 2'($urandom_range(3)), 90, n);
  endtask

  task automatic test_random_phase(input int unsigned idle, input logic keep, input int total);
    int sent;
    int n;
    logic straight;
    set_keep(keep);
    idle_pct = idle;
    sent = 0;
    while (sent < total) begin
      straight = ($urandom_range(7) == 0);
      run_walk(straight, 2'($urandom_range(3)), straight ? 90 : int'($urandom_range(6, 150)),
               n);
      sent += n;
      if ($urandom_range(9) == 0) wait_idle();
    end
  endtask

  always @(posedge clk_i) begin : check_reports
    report_t got;
    report_t want;
    if (rst_ni && done_o === 1'b1) begin
      got = '{status_o, direction_o, forward_o, pos_x_o, pos_y_o, met_seen_o, meet_x_o,
              meet_y_o};
      results_seen++;
      if (expected_reports.size() == 0) begin
        mismatches++;
        if (mismatches <= MAX_REPORTS)
          $display("result %0d with nothing expected: status %0d pos (%0d,%0d)",
                   results_seen, got.status, got.pos_x, got.pos_y);
      end else begin
        want = expected_reports.pop_front();
        status_count[want.status]++;
        if (got.status !== want.status || got.direction !== want.direction ||
            got.forward !== want.forward || got.pos_x !== want.pos_x ||
            got.pos_y !== want.pos_y || got.met_seen !== want.met_seen ||
            got.meet_x !== want.meet_x || got.meet_y !== want.meet_y) begin
          mismatches++;
          if (mismatches <= MAX_REPORTS) begin
            $display("result %0d expected: status %0d dir %0d fwd %0d pos (%0d,%0d)",
                     results_seen, want.status, want.direction, want.forward, want.pos_x,
                     want.pos_y);
            $display("  expected met %0d (%0d,%0d)", want.met_seen, want.meet_x,
                     want.meet_y);
            $display("result %0d actual:   status %0d dir %0d fwd %0d pos (%0d,%0d)",
                     results_seen, got.status, got.direction, got.forward, got.pos_x,
                     got.pos_y);
            $display("  actual met %0d (%0d,%0d)", got.met_seen, got.meet_x, got.meet_y);
          end
        end
      end
    end
  end

  always @(posedge clk_i) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results outstanding", cycles,
               expected_reports.size());
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  initial begin
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_reset_state();
    test_start_cell();
    test_move_and_backtrack();
    test_meeting();
    test_grid_edge();
    test_random_phase(0, 1'b0, 480);
    test_random_phase(71, 1'b1, 480);
    test_random_phase(19, 1'b0, 480);
    test_random_phase(0, 1'b1, 400);
    wait_idle();
    repeat (20) @(posedge clk_i);
    $display("%0d transfers in %0d walks, %0d results, %0d mismatches", items_sent, walks,
             results_seen, mismatches);
    $display("started %0d chosen %0d moved %0d explored %0d met %0d off-grid %0d order %0d",
             status_count[ST_STARTED], status_count[ST_CHOSEN], status_count[ST_MOVED],
             status_count[ST_EXPLORED], status_count[ST_MET], status_count[ST_OFF_GRID],
             status_count[ST_OUT_OF_ORDER]);
    if (mismatches == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
